// File: rtl/rsch_pkg.sv
package rsch_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ID_BITS_DEF    = 16;
  localparam int DIST_BITS_DEF  = 64;
  localparam int IDX_BITS       = 3;

  localparam logic [IDX_BITS-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_DIR_X      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_DIR_Y      = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SKIP_FACE  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_SKIP_EN    = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_NEAR_LIMIT = 3'd6;

endpackage

// File: rtl/rsch_front.sv
// Accepts faces, forms the edge vector and the three cross products, classifies the hit.
module rsch_front #(
  parameter int COORD_BITS = rsch_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = rsch_pkg::ID_BITS_DEF,
  parameter int QW         = 2 * COORD_BITS + 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ID_BITS-1:0]           face_id,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         last_face,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic [ID_BITS-1:0]           skip_face,
  input  logic                         skip_enable,
  output logic                         q_push,
  input  logic                         q_full,
  output logic [ID_BITS-1:0]           q_id,
  output logic                         q_test,
  output logic                         q_last,
  output logic signed [COORD_BITS:0]   q_ax,
  output logic signed [COORD_BITS:0]   q_ay,
  output logic signed [COORD_BITS+1:0] q_ex,
  output logic signed [COORD_BITS+1:0] q_ey,
  output logic signed [QW-1:0]         q_num,
  output logic signed [QW-1:0]         q_den
);
  localparam int CW = COORD_BITS + 2;
  localparam int PW = 2 * CW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_M1   = 3'd1;
  localparam logic [2:0] ST_M2   = 3'd2;
  localparam logic [2:0] ST_M3   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [ID_BITS-1:0] id;
  logic last, skip;
  logic signed [CW-1:0] ax, ay, ex, ey, wx, wy, dx, dy;
  logic signed [PW-1:0] p0, p1, den, num, tn;
  logic signed [CW-1:0] ma, mb, mc, md;
  logic signed [PW-1:0] pa, pb;
  logic test;

  assign full = (state != ST_IDLE);

  always_comb begin
    ma = dx; mb = ey; mc = dy; md = ex;
    case (state)
      ST_M1: begin ma = dx; mb = wy; mc = dy; md = wx; end
      ST_M2: begin ma = ex; mb = -wy; mc = ey; md = -wx; end
      default: begin ma = dx; mb = ey; mc = dy; md = ex; end
    endcase
  end
  assign pa = PW'(ma) * PW'(mb);
  assign pb = PW'(mc) * PW'(md);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (push) state <= ST_M1;
        ST_M1: state <= ST_M2;
        ST_M2: state <= ST_M3;
        ST_M3: state <= ST_OUT;
        ST_OUT: if (!q_full) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (push) begin
        id <= face_id; last <= last_face;
        skip <= skip_enable && (face_id == skip_face);
        ax <= CW'(start_x); ay <= CW'(start_y);
        ex <= CW'(end_x) - CW'(start_x);
        ey <= CW'(end_y) - CW'(start_y);
        wx <= CW'(origin_x) - CW'(start_x);
        wy <= CW'(origin_y) - CW'(start_y);
        dx <= CW'(dir_x); dy <= CW'(dir_y);
      end
      ST_M1: begin p0 <= pa; p1 <= pb; end
      ST_M2: begin num <= p0 - p1; p0 <= pa; p1 <= pb; end
      ST_M3: begin tn <= p0 - p1; den <= pa - pb; end
      default: ;
    endcase
  end

  // num computed as the cross of d with (O-A); tn as cross(E, A-O)
  logic sd, sn, st;
  logic dz, nz, tz;
  assign dz = (den == '0);
  assign nz = (num == '0);
  assign tz = (tn == '0);
  assign sd = den[PW-1];
  assign sn = num[PW-1];
  assign st = tn[PW-1];
  logic signed [PW-1:0] an, ad;
  assign an = sn ? -num : num;
  assign ad = sd ? -den : den;
  assign test = !skip && !dz && (tz || (st != sd)) && (nz || (sn == sd)) && (an <= ad);

  assign q_push = (state == ST_OUT);
  assign q_id   = id;
  assign q_test = test;
  assign q_last = last;
  assign q_ax   = ax[COORD_BITS:0];
  assign q_ay   = ay[COORD_BITS:0];
  assign q_ex   = ex;
  assign q_ey   = ey;
  assign q_num  = QW'(num);
  assign q_den  = QW'(den);
endmodule

// File: rtl/rsch_fifo.sv
// Two-entry queue between front and back.
module rsch_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr && !full) wp <= ~wp;
      if (rd && !empty) rp <= ~rp;
      cnt <= cnt + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("fifo count overflow");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (wr && !full && !rd) |=> !empty)
    else $error("fifo lost a beat");
`endif
endmodule

// File: rtl/rsch_back.sv
// Divides num*E by den per axis, saturates, computes distance, keeps best hit.
module rsch_back #(
  parameter int COORD_BITS = rsch_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = rsch_pkg::ID_BITS_DEF,
  parameter int DIST_BITS  = rsch_pkg::DIST_BITS_DEF,
  parameter int QW         = 2 * COORD_BITS + 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [ID_BITS-1:0]           q_id,
  input  logic                         q_test,
  input  logic                         q_last,
  input  logic signed [COORD_BITS:0]   q_ax,
  input  logic signed [COORD_BITS:0]   q_ay,
  input  logic signed [COORD_BITS+1:0] q_ex,
  input  logic signed [COORD_BITS+1:0] q_ey,
  input  logic signed [QW-1:0]         q_num,
  input  logic signed [QW-1:0]         q_den,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic [DIST_BITS-1:0]         near_limit,
  output logic                         empty,
  input  logic                         pop,
  output logic                         hit,
  output logic [ID_BITS-1:0]           hit_face,
  output logic signed [COORD_BITS-1:0] hit_x,
  output logic signed [COORD_BITS-1:0] hit_y,
  output logic                         too_close
);
  localparam int CW = COORD_BITS + 2;
  localparam int MW = QW + CW;          // |num*E| width (unsigned)
  localparam int CNTW = $clog2(MW + 1);
  localparam int DW = 2 * COORD_BITS + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MLD  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_DSQ  = 3'd5;
  localparam logic [2:0] ST_CMP  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state;
  logic axis;
  logic [CNTW-1:0] cnt;
  logic [ID_BITS-1:0] id;
  logic last;
  logic signed [COORD_BITS:0] ax, ay;
  logic signed [CW-1:0] ex, ey;
  logic [QW-1:0] nmag, dmag;
  logic nneg, dneg;
  logic [CW-1:0] mul_b;
  logic [MW-1:0] dvd, quo;
  logic [QW:0] rem;
  logic qneg;
  logic signed [COORD_BITS-1:0] hx, hy;
  logic [DW-1:0] sqx, sqy;
  logic [DIST_BITS-1:0] dist_cur;

  logic best_valid, best_near;
  logic [DIST_BITS-1:0] best_dist_sq;
  logic [ID_BITS-1:0] best_id;
  logic signed [COORD_BITS-1:0] best_x, best_y;

  logic out_full;
  logic emit_go;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign emit_go = (state == ST_EMIT) && last && (!out_full || pop);

  // |num| * |e| by shift and add, one bit of |e| a cycle, shared by both axes
  logic signed [CW-1:0] ecur;
  logic [CW-1:0] emag;
  assign ecur = axis ? ey : ex;
  assign emag = ecur[CW-1] ? CW'(-ecur) : CW'(ecur);

  logic [QW:0] rsh;
  logic [QW:0] rsub;
  assign rsh  = {rem[QW-1:0], dvd[MW-1]};
  assign rsub = rsh - {1'b0, dmag};

  // saturating add of base and truncated quotient
  localparam int SW = MW + 2;
  logic signed [SW-1:0] qs, sum;
  logic signed [COORD_BITS:0] abase;
  logic signed [COORD_BITS-1:0] satv;
  localparam logic signed [SW-1:0] MAXP = SW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] MINN = -SW'(64'sd1 <<< (COORD_BITS - 1));
  assign abase = axis ? ay : ax;
  assign qs  = qneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign sum = qs + SW'(abase);
  always_comb begin
    if (sum > MAXP) satv = MAXP[COORD_BITS-1:0];
    else if (sum < MINN) satv = MINN[COORD_BITS-1:0];
    else satv = sum[COORD_BITS-1:0];
  end

  logic signed [COORD_BITS:0] ddx, ddy;
  logic [COORD_BITS:0] mdx, mdy;
  assign ddx = (COORD_BITS+1)'(hx) - (COORD_BITS+1)'(origin_x);
  assign ddy = (COORD_BITS+1)'(hy) - (COORD_BITS+1)'(origin_y);
  assign mdx = ddx[COORD_BITS] ? (COORD_BITS+1)'(-ddx) : (COORD_BITS+1)'(ddx);
  assign mdy = ddy[COORD_BITS] ? (COORD_BITS+1)'(-ddy) : (COORD_BITS+1)'(ddy);

  logic [DW:0] dsum;
  assign dsum = {1'b0, sqx} + {1'b0, sqy};

  logic near;
  logic [DIST_BITS-1:0] eff;
  assign near = dist_cur < near_limit;
  assign eff  = near ? '1 : dist_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      best_valid <= 1'b0; best_near <= 1'b0; best_dist_sq <= '1;
      best_id <= '0; best_x <= '0; best_y <= '0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full && !emit_go) out_full <= 1'b0;
      case (state)
        ST_IDLE: if (!q_empty) begin
          id <= q_id; last <= q_last;
          ax <= q_ax; ay <= q_ay; ex <= q_ex; ey <= q_ey;
          nneg <= q_num[QW-1]; dneg <= q_den[QW-1];
          nmag <= q_num[QW-1] ? QW'(-q_num) : QW'(q_num);
          dmag <= q_den[QW-1] ? QW'(-q_den) : QW'(q_den);
          axis <= 1'b0;
          state <= q_test ? ST_MLD : ST_EMIT;
        end
        ST_MLD: begin
          mul_b <= emag;
          dvd <= '0;
          qneg <= nneg ^ dneg ^ ecur[CW-1];
          cnt <= CNTW'(CW);
          state <= ST_MUL;
        end
        ST_MUL: begin
          dvd <= {dvd[MW-2:0], 1'b0} + (mul_b[CW-1] ? MW'(nmag) : MW'(0));
          mul_b <= {mul_b[CW-2:0], 1'b0};
          if (cnt == CNTW'(1)) begin
            rem <= '0; quo <= '0;
            cnt <= CNTW'(MW);
            state <= ST_DIV;
          end else begin
            cnt <= cnt - CNTW'(1);
          end
        end
        ST_DIV: begin
          if (rsub[QW]) begin
            rem <= rsh; quo <= {quo[MW-2:0], 1'b0};
          end else begin
            rem <= rsub; quo <= {quo[MW-2:0], 1'b1};
          end
          dvd <= {dvd[MW-2:0], 1'b0};
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) state <= ST_SAT;
        end
        ST_SAT: begin
          if (axis) begin
            hy <= satv; state <= ST_DSQ;
          end else begin
            hx <= satv; axis <= 1'b1; state <= ST_MLD;
          end
        end
        ST_DSQ: begin
          sqx <= DW'(mdx) * DW'(mdx);
          sqy <= DW'(mdy) * DW'(mdy);
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (eff <= best_dist_sq) begin
            best_valid <= 1'b1; best_near <= near; best_dist_sq <= eff;
            best_id <= id; best_x <= hx; best_y <= hy;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!last) begin
            state <= ST_IDLE;
          end else if (emit_go) begin
            out_full  <= 1'b1;
            hit       <= best_valid;
            hit_face  <= best_valid ? best_id : '0;
            hit_x     <= best_valid ? best_x : '0;
            hit_y     <= best_valid ? best_y : '0;
            too_close <= best_valid && best_near;
            best_valid <= 1'b0; best_near <= 1'b0; best_dist_sq <= '1;
            best_id <= '0; best_x <= '0; best_y <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // distance from the registered squares, saturated; valid in ST_CMP
  logic dsq_d;
  always_ff @(posedge clk) begin
    if (rst) dsq_d <= 1'b0;
    else dsq_d <= (state == ST_DSQ);
  end
  assign dist_cur = (dsum > (DW+1)'({DIST_BITS{1'b1}})) ? '1 : DIST_BITS'(dsum);
  assign empty = !out_full;

`ifndef SYNTHESIS
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != ST_IDLE))
    else $error("queue beat not taken");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> !best_valid)
    else $error("best not cleared after result");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> out_full)
    else $error("result beat lost");
  a_dsq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> dsq_d)
    else $error("compare without squares");
`endif
endmodule

// File: rtl/ray_segment_closest_hit.sv
// channel | handshake       | beat
// faces   | push / full     | face_id, start_x/y, end_x/y, last_face
// results | empty / pop     | hit, hit_face, hit_x, hit_y, too_close
// config  | cfg_we          | cfg_index, cfg_data
// Front: one shared 34x34 multiply pair forms the three cross products in turn, then
// one queue beat; full is held meanwhile. Back: skipped or missing faces go to emit;
// tested faces run the shift-add multiply and bit-serial divider once per axis.
// Reset clears state machines, queue and the running best. Full result
// stalls only faces marked last.
module ray_segment_closest_hit #(
  parameter int COORD_BITS = rsch_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rsch_pkg::FRAC_BITS_DEF,
  parameter int ID_BITS    = rsch_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [ID_BITS-1:0]              face_id,
  input  logic signed [COORD_BITS-1:0]    start_x,
  input  logic signed [COORD_BITS-1:0]    start_y,
  input  logic signed [COORD_BITS-1:0]    end_x,
  input  logic signed [COORD_BITS-1:0]    end_y,
  input  logic                            last_face,
  output logic                            empty,
  input  logic                            pop,
  output logic                            hit,
  output logic [ID_BITS-1:0]              hit_face,
  output logic signed [COORD_BITS-1:0]    hit_x,
  output logic signed [COORD_BITS-1:0]    hit_y,
  output logic                            too_close,
  input  logic                            cfg_we,
  input  logic [rsch_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [2*COORD_BITS-1:0]         cfg_data
);
  localparam int QW = 2 * COORD_BITS + 4;
  localparam int DB = 2 * COORD_BITS;
  localparam int FW = ID_BITS + 2 + 2 * (COORD_BITS + 1) + 2 * (COORD_BITS + 2) + 2 * QW;

  logic signed [COORD_BITS-1:0] origin_x, origin_y, dir_x, dir_y;
  logic [ID_BITS-1:0] skip_face;
  logic skip_enable;
  logic [DB-1:0] near_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_y <= '0;
      dir_x <= COORD_BITS'(64'd1 << FRAC_BITS); dir_y <= '0;
      skip_face <= '0; skip_enable <= 1'b0; near_limit <= DB'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rsch_pkg::REG_ORIGIN_X:   origin_x <= cfg_data[COORD_BITS-1:0];
        rsch_pkg::REG_ORIGIN_Y:   origin_y <= cfg_data[COORD_BITS-1:0];
        rsch_pkg::REG_DIR_X:      dir_x <= cfg_data[COORD_BITS-1:0];
        rsch_pkg::REG_DIR_Y:      dir_y <= cfg_data[COORD_BITS-1:0];
        rsch_pkg::REG_SKIP_FACE:  skip_face <= ID_BITS'(cfg_data);
        rsch_pkg::REG_SKIP_EN:    skip_enable <= cfg_data[0];
        rsch_pkg::REG_NEAR_LIMIT: near_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  logic f_push, f_full, b_pop, b_empty;
  logic [ID_BITS-1:0] f_id, b_id;
  logic f_test, f_last, b_test, b_last;
  logic signed [COORD_BITS:0] f_ax, f_ay, b_ax, b_ay;
  logic signed [COORD_BITS+1:0] f_ex, f_ey, b_ex, b_ey;
  logic signed [QW-1:0] f_num, f_den, b_num, b_den;

  rsch_front #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS), .QW(QW)) u_front (
    .clk, .rst, .push, .full, .face_id, .start_x, .start_y, .end_x, .end_y,
    .last_face, .origin_x, .origin_y, .dir_x, .dir_y, .skip_face, .skip_enable,
    .q_push(f_push), .q_full(f_full), .q_id(f_id), .q_test(f_test),
    .q_last(f_last), .q_ax(f_ax), .q_ay(f_ay), .q_ex(f_ex), .q_ey(f_ey),
    .q_num(f_num), .q_den(f_den)
  );

  rsch_fifo #(.W(FW)) u_fifo (
    .clk, .rst, .wr(f_push), .full(f_full),
    .wdata({f_id, f_test, f_last, f_ax, f_ay, f_ex, f_ey, f_num, f_den}),
    .rd(b_pop), .empty(b_empty),
    .rdata({b_id, b_test, b_last, b_ax, b_ay, b_ex, b_ey, b_num, b_den})
  );

  rsch_back #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS), .DIST_BITS(DB), .QW(QW)) u_back (
    .clk, .rst, .q_empty(b_empty), .q_pop(b_pop), .q_id(b_id), .q_test(b_test),
    .q_last(b_last), .q_ax(b_ax), .q_ay(b_ay), .q_ex(b_ex), .q_ey(b_ey),
    .q_num(b_num), .q_den(b_den), .origin_x, .origin_y, .near_limit,
    .empty, .pop, .hit, .hit_face, .hit_x, .hit_y, .too_close
  );

`ifndef SYNTHESIS
  a_full: assert property (@(posedge clk) disable iff (rst) (push && !full) |=> full)
    else $error("front took two beats");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == rsch_pkg::REG_SKIP_EN) |=> (skip_enable == $past(cfg_data[0])))
    else $error("skip enable write lost");
  a_out: assert property (@(posedge clk) disable iff (rst) (!empty && !pop) |=> !empty)
    else $error("result dropped");
`endif
endmodule
